### rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared constants, types and the arctangent table of the sinc sample pipeline.
// ----------------------------------------------------------------------------
package sws_pkg;

	// table geometry and output scale
	localparam int SAMPLE_COUNT = 8192;
	localparam int HALF         = SAMPLE_COUNT / 2;
	localparam int MIDLEVEL     = 2048;
	localparam int VAL_MAX      = 4095;

	// fixed-point constants
	localparam logic [18:0] TWO_PI_Q16      = 19'd411775;
	localparam int          CORDIC_GAIN_Q30 = 652032874;
	localparam int          CORDIC_STEPS    = 17;
	localparam int          QBITS           = 15;

	// field and datapath widths
	localparam int IDX_W = 13;
	localparam int PC_W  = 10;
	localparam int D_W   = 13;
	localparam int NUM_W = 24;
	localparam int Z_W   = 19;
	localparam int XY_W  = 33;
	localparam int S_W   = 15;
	localparam int DVS_W = 43;
	localparam int DVD_W = S_W + 30;
	localparam int Q_W   = QBITS + 1;
	localparam int VAL_W = 12;

	// sideband that travels with each sample
	typedef struct packed {
		logic             centre;
		logic             neg;
		logic [NUM_W-1:0] num;
	} sws_side_t;

	// round(atan(2^-i) * 2^16)
	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		logic signed [Z_W-1:0] a;
		case (i)
			0:  a = 19'sd51472;
			1:  a = 19'sd30386;
			2:  a = 19'sd16055;
			3:  a = 19'sd8150;
			4:  a = 19'sd4091;
			5:  a = 19'sd2047;
			6:  a = 19'sd1024;
			7:  a = 19'sd512;
			8:  a = 19'sd256;
			9:  a = 19'sd128;
			10: a = 19'sd64;
			11: a = 19'sd32;
			12: a = 19'sd16;
			13: a = 19'sd8;
			14: a = 19'sd4;
			15: a = 19'sd2;
			16: a = 19'sd1;
			default: a = 19'sd0;
		endcase
		return a;
	endfunction

endpackage

### rtl/sws_cordic.sv
// ----------------------------------------------------------------------------
// sws_cordic
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module sws_cordic import sws_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic signed [Z_W-1:0]  z_in,
	input  sws_side_t              side_in,
	output logic                   out_valid,
	output logic signed [XY_W-1:0] y_out,
	output sws_side_t              side_out
);

	logic                   v_sn    [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] x_sn    [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] y_sn    [0:CORDIC_STEPS];
	logic signed [Z_W-1:0]  z_sn    [0:CORDIC_STEPS];
	sws_side_t              side_sn [0:CORDIC_STEPS];

	// load stage: start vector on the x axis at the gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn[0] <= 1'b0;
		end else begin
			v_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_sn[0]    <= XY_W'(CORDIC_GAIN_Q30);
		y_sn[0]    <= '0;
		z_sn[0]    <= z_in;
		side_sn[0] <= side_in;
	end

	// micro-rotations
	for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_rot
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		assign dx = y_sn[k-1] >>> (k-1);
		assign dy = x_sn[k-1] >>> (k-1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[k] <= 1'b0;
			end else begin
				v_sn[k] <= v_sn[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (!z_sn[k-1][Z_W-1]) begin
				x_sn[k] <= x_sn[k-1] - dx;
				y_sn[k] <= y_sn[k-1] + dy;
				z_sn[k] <= z_sn[k-1] - atan_q16(k-1);
			end else begin
				x_sn[k] <= x_sn[k-1] + dx;
				y_sn[k] <= y_sn[k-1] - dy;
				z_sn[k] <= z_sn[k-1] + atan_q16(k-1);
			end
			side_sn[k] <= side_sn[k-1];
		end
	end

	assign out_valid = v_sn[CORDIC_STEPS];
	assign y_out     = y_sn[CORDIC_STEPS];
	assign side_out  = side_sn[CORDIC_STEPS];

endmodule

### rtl/sws_div.sv
// ----------------------------------------------------------------------------
// sws_div
// Pipelined restoring divider for the sinc quotient, saturating at 1.0 in Q1.15.
// ----------------------------------------------------------------------------
module sws_div import sws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [S_W-1:0]   s_in,
	input  logic [DVS_W-1:0] dvs_in,
	input  sws_side_t        side_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   q_out,
	output sws_side_t        side_out
);

	localparam int CMP_W = DVS_W + QBITS;

	logic             v_sn    [0:QBITS];
	logic             sat_sn  [0:QBITS];
	logic [DVD_W-1:0] rem_sn  [0:QBITS];
	logic [QBITS-1:0] q_sn    [0:QBITS];
	logic [DVS_W-1:0] dvs_sn  [0:QBITS];
	sws_side_t        side_sn [0:QBITS];

	logic [DVD_W-1:0] dvd;
	assign dvd = {s_in, 30'd0};

	// first stage: quotient of one or more saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn[0] <= 1'b0;
		end else begin
			v_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sat_sn[0]  <= CMP_W'(dvd) >= (CMP_W'(dvs_in) << QBITS);
		rem_sn[0]  <= dvd;
		q_sn[0]    <= '0;
		dvs_sn[0]  <= dvs_in;
		side_sn[0] <= side_in;
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QBITS; j++) begin : g_bit
		localparam int B = QBITS - j;
		logic [CMP_W-1:0] trial;
		logic             fits;
		assign trial = CMP_W'(dvs_sn[j-1]) << B;
		assign fits  = CMP_W'(rem_sn[j-1]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[j] <= 1'b0;
			end else begin
				v_sn[j] <= v_sn[j-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[j]    <= fits ? DVD_W'(CMP_W'(rem_sn[j-1]) - trial) : rem_sn[j-1];
			q_sn[j]      <= q_sn[j-1] | (QBITS'(fits) << B);
			sat_sn[j]    <= sat_sn[j-1];
			dvs_sn[j]    <= dvs_sn[j-1];
			side_sn[j]   <= side_sn[j-1];
		end
	end

	assign out_valid = v_sn[QBITS];
	assign q_out     = sat_sn[QBITS] ? Q_W'(1 << QBITS) : {1'b0, q_sn[QBITS]};
	assign side_out  = side_sn[QBITS];

endmodule

### rtl/sinc_waveform_sample.sv
// ----------------------------------------------------------------------------
// sinc_waveform_sample
// One 12-bit DAC code of a centred sin(x)/x pulse per table index.
//
// channel   | ports                               | transfer
// ----------+-------------------------------------+--------------------------
// command   | start, busy, sample_index           | start high, busy low
// result    | done, sample_value                  | done high, one cycle
// config    | psel penable pwrite paddr pwdata .. | access phase, pready high
//
// A new index is taken every cycle; busy is never raised.
// Each result passes through 3 front stages, 18 CORDIC stages, one
// sine/divisor stage, 16 divider stages and the output register.
// Reset clears the valid bits and sets period_q to 1.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module sinc_waveform_sample import sws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [IDX_W-1:0] sample_index,
	output logic             done,
	output logic [VAL_W-1:0] sample_value,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic [0:0] REG_PERIOD = 1'b0;

	logic [PC_W-1:0] period_q;

	// configuration register
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PC_W'(1);
		end else if (psel && penable && pwrite && paddr[2] == REG_PERIOD) begin
			period_q <= pwdata[PC_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PERIOD) begin
			prdata = 32'(period_q);
		end
	end

	// stage 1: distance from centre
	logic [IDX_W-1:0] n_fix;
	logic [D_W-1:0]   d_c;
	logic             v_s1;
	logic [D_W-1:0]   d_s1;

	assign n_fix = (sample_index == '0) ? IDX_W'(1) : sample_index;
	assign d_c   = (n_fix >= IDX_W'(HALF)) ? D_W'(n_fix - IDX_W'(HALF))
	                                       : D_W'(IDX_W'(HALF) - n_fix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= d_c;
	end

	// stage 2: phase numerator d*(4p+1)
	logic             v_s2;
	logic             centre_s2;
	logic [NUM_W-1:0] num_s2;
	logic [PC_W+D_W+1:0] num_c;

	assign num_c = (PC_W+D_W+2)'({period_q, 2'b01}) * (PC_W+D_W+2)'(d_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		centre_s2 <= d_s1 == '0;
		num_s2    <= num_c[NUM_W-1:0];
	end

	// stage 3: quadrant fold and angle in radians
	logic [15:0] u_c;
	logic [14:0] uq_c;
	logic [14:0] uf_c;
	logic [33:0] zp_c;
	logic                  v_s3;
	logic signed [Z_W-1:0] z_s3;
	sws_side_t             side_s3;

	assign u_c  = {num_s2[13:0], 2'b00};
	assign uq_c = u_c[14:0];
	assign uf_c = (uq_c > 15'd16384) ? 15'(16'd32768 - 16'(uq_c)) : uq_c;
	assign zp_c = 34'(uf_c) * 34'(TWO_PI_Q16) + 34'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		z_s3           <= Z_W'(zp_c[33:16]);
		side_s3.centre <= centre_s2;
		side_s3.neg    <= u_c[15];
		side_s3.num    <= num_s2;
	end

	// sine
	logic                   cor_v;
	logic signed [XY_W-1:0] cor_y;
	sws_side_t              cor_side;

	sws_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.z_in     (z_s3),
		.side_in  (side_s3),
		.out_valid(cor_v),
		.y_out    (cor_y),
		.side_out (cor_side)
	);

	// stage 4: sine magnitude clamp and divisor
	logic signed [XY_W-16:0] ys_c;
	logic [S_W-1:0]          s_c;
	logic                    v_s4;
	logic [S_W-1:0]          s_s4;
	logic [DVS_W-1:0]        dvs_s4;
	sws_side_t               side_s4;

	assign ys_c = (XY_W-15)'(cor_y >>> 15);

	always_comb begin
		if (ys_c < 0) begin
			s_c = '0;
		end else if (ys_c > (XY_W-15)'(32767)) begin
			s_c = S_W'(32767);
		end else begin
			s_c = ys_c[S_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= cor_v;
		end
	end

	always_ff @(posedge clk) begin
		s_s4    <= s_c;
		dvs_s4  <= DVS_W'(cor_side.num) * DVS_W'(TWO_PI_Q16);
		side_s4 <= cor_side;
	end

	// quotient
	logic           div_v;
	logic [Q_W-1:0] div_q;
	sws_side_t      div_side;

	sws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.s_in     (s_s4),
		.dvs_in   (dvs_s4),
		.side_in  (side_s4),
		.out_valid(div_v),
		.q_out    (div_q),
		.side_out (div_side)
	);

	// output: scale to the DAC range around midlevel
	logic [Q_W+VAL_W-1:0] pw_c;
	logic [VAL_W:0]       prod_c;
	logic [VAL_W:0]       sum_c;
	logic [VAL_W-1:0]     val_c;

	assign pw_c   = (Q_W+VAL_W)'(div_q) * (Q_W+VAL_W)'(MIDLEVEL);
	assign prod_c = (VAL_W+1)'(pw_c >> QBITS);

	always_comb begin
		if (div_side.neg) begin
			sum_c = ((VAL_W+1)'(MIDLEVEL) >= prod_c) ? (VAL_W+1)'(MIDLEVEL) - prod_c : '0;
		end else begin
			sum_c = (VAL_W+1)'(MIDLEVEL) + prod_c;
		end
		if (div_side.centre || sum_c > (VAL_W+1)'(VAL_MAX)) begin
			val_c = VAL_W'(VAL_MAX);
		end else begin
			val_c = sum_c[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		sample_value <= val_c;
	end

`ifndef SYNTHESIS
	// result strobe is a registered copy of the divider output valid
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(div_v))
		else $error("result strobe out of step with pipeline");

	// centre sample always gives full scale
	a_centre_full: assert property (@(posedge clk) disable iff (!arst_n)
		div_v && div_side.centre |=> sample_value == VAL_W'(VAL_MAX))
		else $error("centre sample not full scale");

	// positive lobes never fall below midlevel
	a_pos_half: assert property (@(posedge clk) disable iff (!arst_n)
		div_v && !div_side.neg |=> sample_value >= VAL_W'(MIDLEVEL))
		else $error("positive sample below midlevel");
`endif

endmodule
